@@ hw/rtl/packed_mono_framebuffer_pixel_access_assert.svh @@
// Assertion macros for the packed mono frame buffer pixel access block.
`ifndef PACKED_MONO_FRAMEBUFFER_PIXEL_ACCESS_ASSERT_SVH
`define PACKED_MONO_FRAMEBUFFER_PIXEL_ACCESS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMFB_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("pmfb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMFB_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("pmfb assertion failed");

`endif

@@ hw/rtl/pmfb_pkg.sv @@
// Package: types, codes and constants of the packed mono frame buffer block.
`default_nettype none

package pmfb_pkg;

    // Default sizes
    localparam int MEM_BYTES_DEF = 1024;
    localparam int MAX_DIM_DEF   = 1024;

    // Configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;
    localparam int REG_W  = 11;

    // Register reset values
    localparam logic [REG_W-1:0] DISP_W_RST    = 11'd128;
    localparam logic [REG_W-1:0] DISP_H_RST    = 11'd64;
    localparam logic [REG_W-1:0] BUF_BYTES_RST = 11'd1024;

    // Bit masks for leftmost pixel position
    localparam logic [7:0] MASK_MSB = 8'h80;
    localparam logic [7:0] MASK_LSB = 8'h01;

    typedef enum logic [2:0] {
        REG_DISP_W    = 3'd0,
        REG_DISP_H    = 3'd1,
        REG_ROT       = 3'd2,
        REG_BITREV    = 3'd3,
        REG_BUF_BYTES = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_CCW  = 2'd2,
        ROT_HALF = 2'd3
    } t_rot;

    typedef enum logic [1:0] {
        FN_SET  = 2'd0,
        FN_CLR  = 2'd1,
        FN_READ = 2'd2,
        FN_WIPE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CALC,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_WIPE
    } t_state;

    // Per-pixel access info from the address unit
    typedef struct packed {
        logic       in_range;
        logic       in_buf;
        logic [7:0] mask;
    } t_pix_info;

endpackage

`default_nettype wire

@@ hw/rtl/pmfb_xlate.sv @@
// Two-stage pixel address unit: range check, rotation, mask, byte offset.
`default_nettype none

module pmfb_xlate
    import pmfb_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int MAX_DIM   = MAX_DIM_DEF,
    localparam int AW       = $clog2(MEM_BYTES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_ld_calc,
    input  wire logic              i_ld_addr,
    input  wire logic [15:0]       i_x_coord,
    input  wire logic [15:0]       i_y_coord,
    input  wire logic [REG_W-1:0]  i_disp_w,
    input  wire logic [REG_W-1:0]  i_disp_h,
    input  wire t_rot              i_rot,
    input  wire logic              i_bitrev,
    input  wire logic [REG_W-1:0]  i_buf_bytes,
    output t_pix_info              o_info,
    output logic [AW-1:0]          o_addr
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int BW  = DW - 2;
    localparam int OW  = 2 * DW - 1;
    localparam int LW  = $clog2(MEM_BYTES + 1);
    localparam int CW0 = (OW > LW) ? OW : LW;
    localparam int CW  = (CW0 > REG_W) ? CW0 : REG_W;

    logic [DW-1:0] w, h, ux, uy, xb, yb, bw;
    logic [DW:0]   bw_sum;
    logic          inr;
    logic [7:0]    mask;
    logic [CW-1:0] lim;
    logic [OW-1:0] prod;

    logic [DW-1:0] r_xb, r_yb;
    logic [BW-1:0] r_bwb;
    logic          r_inr;
    logic [7:0]    r_mask;
    logic [OW-1:0] r_off;

    // Clamp logical dimensions to the supported maximum
    always_comb begin
        w = (int'(i_disp_w) > MAX_DIM) ? DW'(MAX_DIM) : DW'(i_disp_w);
        h = (int'(i_disp_h) > MAX_DIM) ? DW'(MAX_DIM) : DW'(i_disp_h);
    end

    // Range check on signed coordinates
    assign inr = !i_x_coord[15] && !i_y_coord[15]
                 && ({1'b0, i_x_coord[14:0]} < 16'(w))
                 && ({1'b0, i_y_coord[14:0]} < 16'(h));
    assign ux  = i_x_coord[DW-1:0];
    assign uy  = i_y_coord[DW-1:0];

    // Rotate into buffer coordinates
    always_comb begin
        unique case (i_rot)
            ROT_NONE: begin
                xb = ux;
                yb = uy;
                bw = w;
            end
            ROT_CW: begin
                xb = h - uy - DW'(1);
                yb = ux;
                bw = h;
            end
            ROT_CCW: begin
                xb = uy;
                yb = w - ux - DW'(1);
                bw = h;
            end
            default: begin
                xb = w - ux - DW'(1);
                yb = h - uy - DW'(1);
                bw = w;
            end
        endcase
    end

    assign bw_sum = {1'b0, bw} + (DW + 1)'(7);
    assign mask   = i_bitrev ? 8'(MASK_LSB << xb[2:0]) : 8'(MASK_MSB >> xb[2:0]);

    // Stage 1: rotated coordinates, bytes per row, range flag, mask
    always_ff @(posedge i_clk) begin
        if (i_ld_calc) begin
            r_xb   <= xb;
            r_yb   <= yb;
            r_bwb  <= bw_sum[DW:3];
            r_inr  <= inr;
            r_mask <= mask;
        end
    end

    // Stage 2: byte offset
    assign prod = OW'(r_yb) * OW'(r_bwb);

    always_ff @(posedge i_clk) begin
        if (i_ld_addr) begin
            r_off <= prod + OW'(r_xb >> 3);
        end
    end

    // Buffer limit, capped at the memory size
    assign lim = (int'(i_buf_bytes) > MEM_BYTES) ? CW'(MEM_BYTES) : CW'(i_buf_bytes);

    assign o_info.in_range = r_inr;
    assign o_info.in_buf   = CW'(r_off) < lim;
    assign o_info.mask     = r_mask;
    assign o_addr          = r_off[AW-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/packed_mono_framebuffer_pixel_access.sv @@
// Top level: packed one-bit-per-pixel frame memory with rotated pixel access.
//
//  channel   | ports                                          | transaction
//  ----------+------------------------------------------------+----------------------------
//  command   | start, busy, i_func, i_x_coord, i_y_coord      | start && !busy at clk edge
//  result    | o_valid, o_status, o_in_range, o_pixel_value   | o_valid for one cycle
//  config    | psel, penable, pwrite, paddr, pwdata, prdata,  | write on psel & penable &
//            | pready                                         | pwrite (pready tied high)
//
// A pixel operation runs from accept to its result strobe through CALC and ADDR
// (two address stages), READ (frame-memory read), WRITE (read-modify-write) and
// the result register; busy drops in the strobe cycle, so the next command can be
// taken from the strobe cycle on. Clear-whole-memory sweeps one byte per cycle.
// After reset the same sweep zeroes the memory, with busy high throughout;
// config writes are taken at any time. Results cannot be stalled.
`default_nettype none

`include "packed_mono_framebuffer_pixel_access_assert.svh"

module packed_mono_framebuffer_pixel_access
    import pmfb_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int MAX_DIM   = MAX_DIM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_func,
    input  wire logic [15:0]       i_x_coord,
    input  wire logic [15:0]       i_y_coord,
    // result
    output logic                   o_valid,
    output logic                   o_status,
    output logic                   o_in_range,
    output logic                   o_pixel_value,
    // config
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

    // Config registers
    logic [REG_W-1:0] r_disp_w, r_disp_h, r_buf_bytes;
    t_rot             r_rot;
    logic             r_bitrev;
    logic             cfg_wr;
    t_cfg_reg         cfg_sel;

    // Control
    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt;
    t_func         r_func;
    logic [15:0]   r_x, r_y;
    logic          accept;

    // Datapath
    t_pix_info     info;
    logic [AW-1:0] pix_addr;
    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    r_rd_data;
    logic          rd_en, mem_we, ld_calc, ld_addr, cnt_step, cnt_last;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          hit;

    // Result
    logic r_valid, r_status, r_inr, r_pix;
    logic n_valid, n_status, n_inr, n_pix;

    // Config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = t_cfg_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w    <= DISP_W_RST;
            r_disp_h    <= DISP_H_RST;
            r_rot       <= ROT_NONE;
            r_bitrev    <= 1'b0;
            r_buf_bytes <= BUF_BYTES_RST;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_DISP_W:    r_disp_w    <= pwdata[REG_W-1:0];
                REG_DISP_H:    r_disp_h    <= pwdata[REG_W-1:0];
                REG_ROT:       r_rot       <= t_rot'(pwdata[1:0]);
                REG_BITREV:    r_bitrev    <= pwdata[0];
                REG_BUF_BYTES: r_buf_bytes <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_DISP_W:    prdata = CFG_DW'(r_disp_w);
            REG_DISP_H:    prdata = CFG_DW'(r_disp_h);
            REG_ROT:       prdata = CFG_DW'(r_rot);
            REG_BITREV:    prdata = CFG_DW'(r_bitrev);
            REG_BUF_BYTES: prdata = CFG_DW'(r_buf_bytes);
            default:       prdata = '0;
        endcase
    end

    // Command capture
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_x    <= i_x_coord;
            r_y    <= i_y_coord;
        end
    end

    // Address unit
    pmfb_xlate #(
        .MEM_BYTES (MEM_BYTES),
        .MAX_DIM   (MAX_DIM)
    ) u_xlate (
        .i_clk       (i_clk),
        .i_ld_calc   (ld_calc),
        .i_ld_addr   (ld_addr),
        .i_x_coord   (r_x),
        .i_y_coord   (r_y),
        .i_disp_w    (r_disp_w),
        .i_disp_h    (r_disp_h),
        .i_rot       (r_rot),
        .i_bitrev    (r_bitrev),
        .i_buf_bytes (r_buf_bytes),
        .o_info      (info),
        .o_addr      (pix_addr)
    );

    // State register and sweep counter
    assign cnt_last = (r_cnt == LAST_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (cnt_step) begin
                r_cnt <= cnt_last ? '0 : r_cnt + AW'(1);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: if (cnt_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    n_state = (t_func'(i_func) == FN_WIPE) ? ST_WIPE : ST_CALC;
                end
            end
            ST_CALC:  n_state = ST_ADDR;
            ST_ADDR:  n_state = ST_READ;
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            ST_WIPE:  if (cnt_last) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    assign hit = info.in_range && info.in_buf;

    always_comb begin
        ld_calc  = 1'b0;
        ld_addr  = 1'b0;
        rd_en    = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = pix_addr;
        mem_wd   = r_rd_data;
        cnt_step = 1'b0;
        n_valid  = 1'b0;
        n_status = 1'b0;
        n_inr    = 1'b0;
        n_pix    = 1'b0;
        unique case (r_state)
            ST_SWEEP: begin
                mem_we   = 1'b1;
                mem_wa   = r_cnt;
                mem_wd   = '0;
                cnt_step = 1'b1;
            end
            ST_WIPE: begin
                mem_we   = 1'b1;
                mem_wa   = r_cnt;
                mem_wd   = '0;
                cnt_step = 1'b1;
                n_valid  = cnt_last;
            end
            ST_CALC: ld_calc = 1'b1;
            ST_ADDR: ld_addr = 1'b1;
            ST_READ: rd_en   = hit;
            ST_WRITE: begin
                n_valid = 1'b1;
                n_inr   = info.in_range;
                unique case (r_func)
                    FN_SET: begin
                        mem_we = hit;
                        mem_wd = r_rd_data | info.mask;
                    end
                    FN_CLR: begin
                        mem_we   = hit;
                        mem_wd   = r_rd_data & ~info.mask;
                        n_status = info.in_range && !info.in_buf;
                    end
                    default: begin
                        n_status = info.in_range && !info.in_buf;
                        n_pix    = hit && (|(r_rd_data & info.mask));
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Frame memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[pix_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_status <= n_status;
            r_inr    <= n_inr;
            r_pix    <= n_pix;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_in_range    = r_inr;
    assign o_pixel_value = r_pix;

    // Checks
    `PMFB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `PMFB_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    `PMFB_ASSERT_IMPL(a_strobe_after_work, i_clk, i_rst_n, o_valid, $past(busy))
    `PMFB_ASSERT_IMPL(a_write_in_buf, i_clk, i_rst_n,
        (r_state == ST_WRITE) && mem_we, info.in_range && info.in_buf)

endmodule

`default_nettype wire
